// ===== rtl/rfb_pkg.sv =====
// Shared types and constants of the rectangle fill and blend engine.
// No dependencies; used by rfb_blend and rect_fill_blend_engine.
package rfb_pkg;

  localparam int PIX_W   = 32;  // RGBA word
  localparam int COORD_W = 8;   // x and y coordinates
  localparam int LW_W    = 9;   // line width register
  localparam int CNT_W   = 17;  // pixels written per request
  localparam int ROW_W   = 17;  // linear address before the store bound check

  // request codes
  localparam logic [1:0] OP_FILL  = 2'd0;
  localparam logic [1:0] OP_BLEND = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // one product per color channel, 8 x 8 bits
  typedef struct packed {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
  } mix_terms_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SETUP = 7'b0000010,
    ST_RUN   = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_READ  = 7'b0010000,
    ST_READW = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

endpackage

// ===== rtl/rfb_blend.sv =====
// Per-pixel blend datapath: destination products (registered), then sum and divide by 255.
// Depends on rfb_pkg for mix_terms_t.
module rfb_blend (
  input  logic                       clk,
  input  logic [31:0]                dst_i,
  input  logic [7:0]                 inv_a_i,
  input  rfb_pkg::mix_terms_t        src_terms_i,
  output logic [31:0]                pix_o
);

  rfb_pkg::mix_terms_t dst_mul_r;

  // (s + d) / 255 for s + d <= 255*255, exact by the add-high-byte trick
  function automatic logic [7:0] mix_div(input logic [15:0] s, input logic [15:0] d);
    logic [16:0] sum;
    logic [16:0] t;
    sum = {1'b0, s} + {1'b0, d};
    t   = sum + 17'd1 + {9'd0, sum[15:8]};
    return t[15:8];
  endfunction

  // stage 1: dst * (255 - alpha) per channel
  always_ff @(posedge clk) begin
    dst_mul_r.r <= 16'(dst_i[31:24]) * 16'(inv_a_i);
    dst_mul_r.g <= 16'(dst_i[23:16]) * 16'(inv_a_i);
    dst_mul_r.b <= 16'(dst_i[15:8])  * 16'(inv_a_i);
  end

  // stage 2: add source term and divide; alpha byte forced opaque
  assign pix_o = {mix_div(src_terms_i.r, dst_mul_r.r),
                  mix_div(src_terms_i.g, dst_mul_r.g),
                  mix_div(src_terms_i.b, dst_mul_r.b),
                  8'hFF};

endmodule

// ===== rtl/rect_fill_blend_engine.sv =====
// Top level of the rectangle fill and alpha blend engine: control, frame store and address walk.
// Depends on rfb_pkg and rfb_blend.
//
//  channel | ports                                   | transfer
//  --------+-----------------------------------------+------------------------------
//  in      | in_valid/in_ready, in_op .. in_alpha    | one request per accept
//  out     | out_valid/out_ready, out_pixel_value,   | one result per request
//          | out_pixels_touched                      |
//  cfg     | cfg_we, cfg_wdata                       | line width, written when we=1
//
// Fill and blend walk the clipped rectangle, issuing one pixel per cycle into the
// read / multiply / write-back pipe on the single port pair of the frame store. A pixel
// read passes through the READ and READW states; an empty rectangle or an unused op goes
// from SETUP straight to DONE.
// Reset sets the line width to 256; the frame store is not cleared.
// A request is taken while an earlier result still waits; a finished result waits for
// out_ready before the next request is taken.
module rect_fill_blend_engine #(
  parameter int STORE_WIDTH  = 256,
  parameter int STORE_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_x_left,
  input  logic [7:0]  in_y_top,
  input  logic [7:0]  in_x_right,
  input  logic [7:0]  in_y_bottom,
  input  logic [31:0] in_color,
  input  logic [7:0]  in_alpha,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel_value,
  output logic [16:0] out_pixels_touched,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata
);

  localparam int DEPTH    = STORE_WIDTH * STORE_HEIGHT;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W    = (ADDR_W > rfb_pkg::ROW_W) ? ADDR_W : rfb_pkg::ROW_W;
  localparam int LAST_ROW = STORE_HEIGHT - 1;

  rfb_pkg::state_t state_r, state_nxt;

  logic [8:0]  line_width_r;
  logic [1:0]  op_r;
  logic [7:0]  x0_r, x1_r, y1_r, cur_x_r, cur_y_r;
  logic [31:0] color_r;
  logic [7:0]  alpha_r, inv_a_r;
  logic [8:0]  stride_r;
  logic        empty_r, vis_r, rd_ok_r;
  logic [16:0] row_base_r;
  logic [16:0] cnt_r;
  logic [31:0] res_pix_r;
  rfb_pkg::mix_terms_t src_terms_r;

  logic              p1_v_r, p2_v_r;
  logic [ADDR_W-1:0] p1_addr_r, p2_addr_r;
  logic [31:0]       rd_q_r;
  logic [31:0]       blend_pix;
  logic [31:0]       wdata;

  logic [31:0]       out_pixel_value_r;
  logic [16:0]       out_pixels_touched_r;
  logic              out_valid_r;

  logic [31:0] mem [DEPTH];

  // stride clamp and clipping of the incoming request
  logic [8:0]  stride_in, last_col;
  logic [7:0]  x1_clip, y1_clip;
  logic        accept, load_out;

  always_comb begin
    stride_in = (line_width_r == 9'd0) ? 9'd1 : line_width_r;
    if ({4'd0, stride_in} > 13'(STORE_WIDTH)) begin
      stride_in = 9'(STORE_WIDTH);
    end
    last_col = stride_in - 9'd1;
    x1_clip  = ({1'b0, in_x_right} > last_col) ? last_col[7:0] : in_x_right;
    y1_clip  = ({5'd0, in_y_bottom} > 13'(LAST_ROW)) ? 8'(LAST_ROW) : in_y_bottom;
  end

  assign in_ready = (state_r == rfb_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == rfb_pkg::ST_DONE) && (!out_valid_r || out_ready);

  // current linear address and store bound check
  logic [16:0]      addr;
  logic             in_store;
  logic [IDX_W-1:0] addr_wide;

  assign addr      = row_base_r + {9'd0, cur_x_r};
  assign in_store  = ({15'd0, addr} < 32'(DEPTH));
  assign addr_wide = IDX_W'(addr);

  logic row_end, last_px;
  assign row_end = (cur_x_r == x1_r);
  assign last_px = row_end && (cur_y_r == y1_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rfb_pkg::ST_IDLE:  if (accept) state_nxt = rfb_pkg::ST_SETUP;
      rfb_pkg::ST_SETUP: begin
        if (op_r == rfb_pkg::OP_READ) begin
          state_nxt = rfb_pkg::ST_READ;
        end else if ((op_r == rfb_pkg::OP_FILL || op_r == rfb_pkg::OP_BLEND) && !empty_r) begin
          state_nxt = rfb_pkg::ST_RUN;
        end else begin
          state_nxt = rfb_pkg::ST_DONE;
        end
      end
      rfb_pkg::ST_RUN:   if (last_px) state_nxt = rfb_pkg::ST_DRAIN;
      rfb_pkg::ST_DRAIN: if (!p1_v_r && !p2_v_r) state_nxt = rfb_pkg::ST_DONE;
      rfb_pkg::ST_READ:  state_nxt = rfb_pkg::ST_READW;
      rfb_pkg::ST_READW: state_nxt = rfb_pkg::ST_DONE;
      rfb_pkg::ST_DONE:  if (load_out) state_nxt = rfb_pkg::ST_IDLE;
      default:           state_nxt = rfb_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rfb_pkg::ST_IDLE;
      line_width_r <= 9'd256;
      p1_v_r       <= 1'b0;
      p2_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        line_width_r <= cfg_wdata;
      end
      p1_v_r <= (state_r == rfb_pkg::ST_RUN) && in_store;
      p2_v_r <= p1_v_r;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture, setup and address walk
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      x0_r     <= in_x_left;
      x1_r     <= x1_clip;
      y1_r     <= y1_clip;
      cur_x_r  <= in_x_left;
      cur_y_r  <= in_y_top;
      color_r  <= in_color;
      alpha_r  <= in_alpha;
      inv_a_r  <= 8'd255 - in_alpha;
      stride_r <= stride_in;
      empty_r  <= (in_x_left > x1_clip) || (in_y_top > y1_clip);
      vis_r    <= ({1'b0, in_x_left} <= last_col) && ({5'd0, in_y_top} <= 13'(LAST_ROW));
      cnt_r    <= 17'd0;
    end
    unique case (state_r)
      rfb_pkg::ST_SETUP: begin
        row_base_r    <= 17'(cur_y_r) * 17'(stride_r);
        src_terms_r.r <= 16'(color_r[31:24]) * 16'(alpha_r);
        src_terms_r.g <= 16'(color_r[23:16]) * 16'(alpha_r);
        src_terms_r.b <= 16'(color_r[15:8])  * 16'(alpha_r);
        res_pix_r     <= 32'd0;
      end
      rfb_pkg::ST_RUN: begin
        if (in_store) begin
          cnt_r <= cnt_r + 17'd1;
        end
        if (row_end) begin
          cur_x_r    <= x0_r;
          cur_y_r    <= cur_y_r + 8'd1;
          row_base_r <= row_base_r + {8'd0, stride_r};
        end else begin
          cur_x_r <= cur_x_r + 8'd1;
        end
      end
      rfb_pkg::ST_READ:  rd_ok_r <= vis_r && in_store;
      rfb_pkg::ST_READW: res_pix_r <= rd_ok_r ? rd_q_r : 32'd0;
      default: ;
    endcase
  end

  // pipe addresses: p1 holds read data, p2 writes back
  always_ff @(posedge clk) begin
    p1_addr_r <= addr_wide[ADDR_W-1:0];
    p2_addr_r <= p1_addr_r;
  end

  // frame store: one read and one write port, registered read
  always_ff @(posedge clk) begin
    rd_q_r <= mem[addr_wide[ADDR_W-1:0]];
  end

  assign wdata = (op_r == rfb_pkg::OP_FILL) ? color_r : blend_pix;

  always_ff @(posedge clk) begin
    if (p2_v_r) begin
      mem[p2_addr_r] <= wdata;
    end
  end

  rfb_blend u_blend (
    .clk         (clk),
    .dst_i       (rd_q_r),
    .inv_a_i     (inv_a_r),
    .src_terms_i (src_terms_r),
    .pix_o       (blend_pix)
  );

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pixel_value_r    <= res_pix_r;
      out_pixels_touched_r <= cnt_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pixel_value    = out_pixel_value_r;
  assign out_pixels_touched = out_pixels_touched_r;

endmodule

// ===== tb/tb_rect_fill_blend_engine.sv =====
// Self-checking testbench for rect_fill_blend_engine: random and directed fill, blend and read
// requests, checked against a shadow copy of the frame store. Depends on rfb_pkg and the RTL.
module tb_rect_fill_blend_engine;

  localparam int STORE_W = 256;
  localparam int STORE_H = 256;
  localparam logic [1:0] OP_NONE = 2'd3;  // unused code, must do nothing

  typedef struct packed {
    logic [1:0]                  op;
    logic [rfb_pkg::COORD_W-1:0] x_left;
    logic [rfb_pkg::COORD_W-1:0] y_top;
    logic [rfb_pkg::COORD_W-1:0] x_right;
    logic [rfb_pkg::COORD_W-1:0] y_bottom;
    logic [rfb_pkg::PIX_W-1:0]   color;
    logic [7:0]                  alpha;
  } rect_req_t;

  typedef struct packed {
    logic [rfb_pkg::PIX_W-1:0] pixel_value;
    logic [rfb_pkg::CNT_W-1:0] pixels_touched;
  } rect_result_t;

  // DUT ports, all driven from time zero
  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [1:0]                  in_op = rfb_pkg::OP_FILL;
  logic [rfb_pkg::COORD_W-1:0] in_x_left = '0;
  logic [rfb_pkg::COORD_W-1:0] in_y_top = '0;
  logic [rfb_pkg::COORD_W-1:0] in_x_right = '0;
  logic [rfb_pkg::COORD_W-1:0] in_y_bottom = '0;
  logic [rfb_pkg::PIX_W-1:0]   in_color = '0;
  logic [7:0]                  in_alpha = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [rfb_pkg::PIX_W-1:0]   out_pixel_value;
  logic [rfb_pkg::CNT_W-1:0]   out_pixels_touched;
  logic                        cfg_we = 1'b0;
  logic [rfb_pkg::LW_W-1:0]    cfg_wdata = '0;

  // shadow state of the engine
  logic [rfb_pkg::PIX_W-1:0] shadow_store [0:STORE_W*STORE_H-1];
  logic [rfb_pkg::LW_W-1:0]  shadow_line_width = 9'd256;

  rect_req_t    pending_reqs[$];
  rect_result_t expected_results[$];
  rect_req_t    cur_req;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int big_left = 3;       // budget of full-size random rectangles
  int n_mismatch = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_widths = 0;
  int op_count [4] = '{0, 0, 0, 0};

  rect_fill_blend_engine u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_x_left          (in_x_left),
    .in_y_top           (in_y_top),
    .in_x_right         (in_x_right),
    .in_y_bottom        (in_y_bottom),
    .in_color           (in_color),
    .in_alpha           (in_alpha),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pixel_value    (out_pixel_value),
    .out_pixels_touched (out_pixels_touched),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  always #6 clk = ~clk;

  // row stride as the engine uses it: 0 acts as 1, wide values saturate
  function automatic int eff_stride();
    int s;
    s = int'(shadow_line_width);
    if (s == 0) s = 1;
    if (s > STORE_W) s = STORE_W;
    return s;
  endfunction

  function automatic logic [rfb_pkg::PIX_W-1:0] blend_word(logic [rfb_pkg::PIX_W-1:0] dst,
                                                           logic [rfb_pkg::PIX_W-1:0] src,
                                                           int a);
    logic [rfb_pkg::PIX_W-1:0] w;
    w = 32'h0000_00FF;
    for (int c = 1; c < 4; c++)
      w[c*8 +: 8] = 8'((int'(src[c*8 +: 8]) * a + int'(dst[c*8 +: 8]) * (255 - a)) / 255);
    return w;
  endfunction

  // apply one request to the shadow store and return the result it must produce
  function automatic rect_result_t render_request(rect_req_t r);
    rect_result_t res;
    int stride, last_col, x0, y0, x1, y1, addr, touched;
    res = '0;
    touched = 0;
    stride = eff_stride();
    last_col = stride - 1;
    x0 = int'(r.x_left);
    y0 = int'(r.y_top);
    x1 = (int'(r.x_right) > last_col) ? last_col : int'(r.x_right);
    y1 = (int'(r.y_bottom) > STORE_H - 1) ? STORE_H - 1 : int'(r.y_bottom);
    if (r.op == rfb_pkg::OP_READ) begin
      if (x0 <= last_col && y0 <= STORE_H - 1) begin
        addr = y0 * stride + x0;
        if (addr < STORE_W * STORE_H) res.pixel_value = shadow_store[addr];
      end
    end else if (r.op == rfb_pkg::OP_FILL || r.op == rfb_pkg::OP_BLEND) begin
      for (int y = y0; y <= y1; y++) begin
        for (int x = x0; x <= x1; x++) begin
          addr = y * stride + x;
          if (addr < STORE_W * STORE_H) begin
            if (r.op == rfb_pkg::OP_FILL) shadow_store[addr] = r.color;
            else shadow_store[addr] = blend_word(shadow_store[addr], r.color, int'(r.alpha));
            touched++;
          end
        end
      end
    end
    res.pixels_touched = touched[rfb_pkg::CNT_W-1:0];
    return res;
  endfunction

  // request driver: present the next pending request, hold it until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(render_request(cur_req));
        op_count[cur_req.op]++;
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_valid    <= 1'b1;
          in_op       <= cur_req.op;
          in_x_left   <= cur_req.x_left;
          in_y_top    <= cur_req.y_top;
          in_x_right  <= cur_req.x_right;
          in_y_bottom <= cur_req.y_bottom;
          in_color    <= cur_req.color;
          in_alpha    <= cur_req.alpha;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: random back-pressure, compare against the oldest expectation
  always @(posedge clk) begin
    rect_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request outstanding: pixel_value %h pixels_touched %0d",
                   $time, out_pixel_value, out_pixels_touched);
          n_mismatch++;
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (out_pixel_value !== want.pixel_value) begin
            $display("%0t: pixel_value expected %h got %h", $time,
                     want.pixel_value, out_pixel_value);
            n_mismatch++;
          end
          if (out_pixels_touched !== want.pixels_touched) begin
            $display("%0t: pixels_touched expected %0d got %0d", $time,
                     want.pixels_touched, out_pixels_touched);
            n_mismatch++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_req(logic [1:0] op, int xl, int yt, int xr, int yb,
                          logic [rfb_pkg::PIX_W-1:0] color, int alpha);
    rect_req_t r;
    r.op = op;
    r.x_left = 8'(xl);
    r.y_top = 8'(yt);
    r.x_right = 8'(xr);
    r.y_bottom = 8'(yb);
    r.color = color;
    r.alpha = 8'(alpha);
    pending_reqs.push_back(r);
  endtask

  // sender holds off until every request has been answered and the engine settled
  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // new phase: drain, then write the line width while idle
  task automatic begin_phase(logic [rfb_pkg::LW_W-1:0] width, int send_pct, int recv_pct);
    wait_drained();
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= width;
    shadow_line_width = width;
    n_widths++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_random(int count);
    rect_req_t r;
    int pick, stride, xl, yt, xe, ye;
    stride = eff_stride();
    for (int i = 0; i < count; i++) begin
      pick = int'($urandom_range(99));
      r.op = (pick < 35) ? rfb_pkg::OP_FILL : (pick < 70) ? rfb_pkg::OP_BLEND :
             (pick < 95) ? rfb_pkg::OP_READ : OP_NONE;
      r.color = $urandom;
      pick = int'($urandom_range(9));
      r.alpha = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(255));
      if (big_left > 0 && $urandom_range(39) == 0) begin
        // occasional large rectangle, any corners
        big_left--;
        r.x_left = 8'($urandom_range(255));
        r.y_top = 8'($urandom_range(255));
        r.x_right = 8'($urandom_range(255));
        r.y_bottom = 8'($urandom_range(255));
      end else if ($urandom_range(9) == 0) begin
        // inverted corners, nothing may be written
        xl = int'($urandom_range(255, 1));
        r.x_left = 8'(xl);
        r.x_right = 8'($urandom_range(xl - 1));
        r.y_top = 8'($urandom_range(255));
        r.y_bottom = 8'($urandom_range(255));
      end else begin
        // small rectangle, often inside the visible columns
        xl = ($urandom_range(2) == 0) ? int'($urandom_range(255))
                                      : int'($urandom_range(stride - 1));
        yt = int'($urandom_range(255));
        xe = xl + int'($urandom_range(15));
        ye = yt + int'($urandom_range(15));
        r.x_left = 8'(xl);
        r.y_top = 8'(yt);
        r.x_right = (xe > 255) ? 8'd255 : 8'(xe);
        r.y_bottom = (ye > 255) ? 8'd255 : 8'(ye);
      end
      pending_reqs.push_back(r);
    end
  endtask

  // stimulus sequence
  initial begin
    for (int i = 0; i < STORE_W * STORE_H; i++) shadow_store[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // full stride; the first request writes every pixel so later reads are defined
    begin_phase(9'd256, 0, 0);
    push_req(rfb_pkg::OP_FILL, 0, 0, 255, 255, 32'h1234_5678, 0);
    push_req(rfb_pkg::OP_READ, 0, 0, 0, 0, 32'h0, 0);
    push_req(rfb_pkg::OP_READ, 255, 255, 0, 0, 32'hFFFF_FFFF, 255);
    push_req(rfb_pkg::OP_FILL, 255, 255, 255, 255, 32'hFFFF_FFFF, 0);
    push_req(rfb_pkg::OP_READ, 255, 255, 255, 255, 32'h0, 0);
    push_req(rfb_pkg::OP_BLEND, 240, 0, 255, 3, 32'hA0B0_C0D0, 128);
    push_req(rfb_pkg::OP_BLEND, 0, 0, 3, 3, 32'hFFFF_FFFF, 0);
    push_req(rfb_pkg::OP_BLEND, 0, 0, 1, 1, 32'h0000_0000, 255);
    push_req(rfb_pkg::OP_READ, 1, 1, 0, 0, 32'h0, 0);
    push_req(rfb_pkg::OP_READ, 2, 2, 0, 0, 32'h0, 0);
    push_req(rfb_pkg::OP_FILL, 10, 0, 5, 3, 32'h5555_5555, 0);
    push_req(rfb_pkg::OP_BLEND, 0, 9, 3, 2, 32'hAAAA_AAAA, 200);
    push_req(OP_NONE, 0, 0, 255, 255, 32'hFFFF_FFFF, 255);
    push_req(rfb_pkg::OP_FILL, 128, 128, 128, 130, 32'h0, 0);
    push_req(rfb_pkg::OP_READ, 128, 129, 0, 0, 32'h0, 0);

    // one column: clipping and invisible reads
    begin_phase(9'd1, 0, 0);
    push_req(rfb_pkg::OP_FILL, 0, 0, 255, 255, 32'hCAFE_F00D, 0);
    push_req(rfb_pkg::OP_READ, 1, 0, 0, 0, 32'h0, 0);
    push_req(rfb_pkg::OP_READ, 0, 255, 0, 0, 32'h0, 0);
    push_req(rfb_pkg::OP_BLEND, 5, 5, 9, 9, 32'h1111_1111, 99);

    // zero width acts as one, oversized width acts as full
    begin_phase(9'd0, 0, 0);
    push_req(rfb_pkg::OP_BLEND, 0, 0, 0, 255, 32'h8040_20FF, 77);
    push_req(rfb_pkg::OP_READ, 0, 200, 0, 0, 32'h0, 0);
    begin_phase(9'd511, 0, 0);
    push_req(rfb_pkg::OP_FILL, 250, 250, 255, 255, 32'h0F0F_0F0F, 0);
    push_req(rfb_pkg::OP_READ, 255, 250, 0, 0, 32'h0, 0);

    // random requests under the idle and stall mixes
    begin_phase(9'd256, 0, 0);
    queue_random(20);
    begin_phase(9'd100, 64, 0);
    queue_random(20);
    begin_phase(9'd511, 0, 64);
    queue_random(20);
    begin_phase(9'd0, 28, 28);
    queue_random(15);
    begin_phase(9'd200, 28, 28);
    queue_random(20);
    begin_phase(9'd256, 64, 64);
    queue_random(20);

    wait_drained();
    repeat (16) @(negedge clk);
    $display("run covered %0d requests (fill %0d, blend %0d, read %0d, unused %0d)",
             n_sent, op_count[rfb_pkg::OP_FILL], op_count[rfb_pkg::OP_BLEND],
             op_count[rfb_pkg::OP_READ], op_count[OP_NONE]);
    $display("%0d results checked over %0d line width settings, %0d mismatches",
             n_checked, n_widths, n_mismatch);
    if (n_mismatch == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("timeout: %0d results still expected", expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
